>>> rtl/cpu_cluster_power_vote_tree_defines.svh
// ---------------------------------------------------------------------------
// cpu cluster power vote tree assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef CPU_CLUSTER_POWER_VOTE_TREE_DEFINES_SVH
`define CPU_CLUSTER_POWER_VOTE_TREE_DEFINES_SVH

// same-cycle implication
`define CCPVT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccpvt assertion failed");

// next-cycle implication
`define CCPVT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccpvt assertion failed");

`endif

>>> rtl/ccpvt_pkg.sv
// ---------------------------------------------------------------------------
// cpu cluster power vote tree package
// transaction types, vote codes and register indexes
// ---------------------------------------------------------------------------
package ccpvt_pkg;

    localparam int KIND_BITS      = 2;
    localparam int CPU_IDX_BITS   = 3;
    localparam int MASK_BITS      = 8;
    localparam int NUM_CPUS_BITS  = 4;
    localparam int NUM_CL_BITS    = 3;
    localparam int MAP_BITS       = 24;
    localparam int MAP_FIELD_BITS = 3;
    localparam int MAP_CPUS       = 8;
    localparam int REPORT_BITS    = 4;
    localparam int POP_BITS       = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [KIND_BITS-1:0] KIND_OFF    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ON     = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RESYNC = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_CPUS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_CLUSTERS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CPU_MAP      = 2'd2;

    localparam logic [NUM_CPUS_BITS-1:0] NUM_CPUS_RESET = 4'd8;
    localparam logic [NUM_CL_BITS-1:0]   NUM_CL_RESET   = 3'd4;

    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [CPU_IDX_BITS-1:0] cpu_index;
        logic                    level;
        logic [MASK_BITS-1:0]    online_mask;
    } vote_in_t;

    typedef struct packed {
        logic                   subsystem_off;
        logic                   cluster_off;
        logic [REPORT_BITS-1:0] subsystem_count;
        logic [REPORT_BITS-1:0] cluster_count;
        logic                   count_error;
    } vote_out_t;

endpackage

>>> rtl/cpu_cluster_power_vote_tree.sv
// ---------------------------------------------------------------------------
// cpu cluster power vote tree
// saturating power-on vote counters per cpu, per cluster and for the subsystem
// ---------------------------------------------------------------------------
// One transaction is taken every clock cycle unless in_stall is raised by a
// stalled output. Each one lands in an input register, and once the output
// register is free a single pass of logic updates the cpu, cluster and
// subsystem counter registers and loads the result register. A resync is
// handled in that same pass by a per-cluster count of the online mask. The
// counters reset to zero at once; there is no clearing sweep. Configuration
// writes take effect on the next cycle and are meant for an idle block.
module cpu_cluster_power_vote_tree #(
    parameter int MAX_CPUS     = 8,
    parameter int MAX_CLUSTERS = 4,
    parameter int COUNT_BITS   = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ccpvt_pkg::vote_in_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ccpvt_pkg::vote_out_t                  out_data,
    input  logic                                  cfg_we,
    input  logic [ccpvt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ccpvt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import ccpvt_pkg::*;

`include "cpu_cluster_power_vote_tree_defines.svh"

    localparam int NUM_MAP_CPUS = (MAX_CPUS < MAP_CPUS) ? MAX_CPUS : MAP_CPUS;
    localparam int CMAX_INT     = (2 ** COUNT_BITS) - 1;
    localparam int RW           = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [NUM_CPUS_BITS-1:0] num_cpus_reg;
    logic [NUM_CL_BITS-1:0]   num_clusters_reg;
    logic [MAP_BITS-1:0]      cpu_map_reg;

    logic      s1_valid_reg;
    vote_in_t  s1_data_reg;
    logic      out_valid_reg;
    vote_out_t out_data_reg;
    vote_out_t result_next;

    logic [COUNT_BITS-1:0] cpu_votes_reg  [MAX_CPUS];
    logic [COUNT_BITS-1:0] cpu_votes_next [MAX_CPUS];
    logic [COUNT_BITS-1:0] cl_votes_reg   [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] cl_votes_next  [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] sub_votes_reg;
    logic [COUNT_BITS-1:0] sub_votes_next;

    logic [MAX_CPUS-1:0]     cpu_en;
    logic [MAX_CLUSTERS-1:0] cl_en;
    logic [MAX_CPUS-1:0]     sel_cpu;
    logic [MAX_CLUSTERS-1:0] cpu_in_cl [NUM_MAP_CPUS];
    logic [MAX_CLUSTERS-1:0] cl_hit;
    logic [POP_BITS-1:0]     cl_pop [MAX_CLUSTERS];
    logic [POP_BITS-1:0]     sub_pop;

    logic                  out_free;
    logic                  fire;
    logic                  vote_up;
    logic                  step_err;
    logic [COUNT_BITS:0]   bres;
    logic [COUNT_BITS-1:0] ccount;
    logic [RW-1:0]         sub_wide;
    logic [RW-1:0]         cl_wide;

    // saturating step, msb flags saturation
    function automatic logic [COUNT_BITS:0] bump(input logic [COUNT_BITS-1:0] v,
                                                 input logic up);
        logic sat;
        sat = up ? (v == CMAX) : (v == '0);
        return {sat, sat ? v : (up ? v + 1'b1 : v - 1'b1)};
    endfunction

    // clamp of a resync count, msb flags saturation
    function automatic logic [COUNT_BITS:0] clamp_pop(input logic [POP_BITS-1:0] p);
        logic sat;
        sat = int'(p) > CMAX_INT;
        return {sat, sat ? CMAX : COUNT_BITS'(p)};
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // cpu and cluster membership from configuration
    always_comb
    begin
        for (int i = 0; i < MAX_CPUS; i++)
        begin
            cpu_en[i]  = NUM_CPUS_BITS'(i) < num_cpus_reg;
            sel_cpu[i] = (NUM_CPUS_BITS'(s1_data_reg.cpu_index) == NUM_CPUS_BITS'(i))
                         && cpu_en[i];
        end
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            cl_en[c] = NUM_CL_BITS'(c) < num_clusters_reg;
        end
        for (int i = 0; i < NUM_MAP_CPUS; i++)
        begin
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                cpu_in_cl[i][c] = cpu_en[i] && cl_en[c] &&
                    (cpu_map_reg[MAP_FIELD_BITS*i +: MAP_FIELD_BITS] ==
                     MAP_FIELD_BITS'(c));
            end
        end
        cl_hit  = '0;
        sub_pop = '0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            cl_pop[c] = '0;
        end
        for (int i = 0; i < NUM_MAP_CPUS; i++)
        begin
            cl_hit  = cl_hit | (cpu_in_cl[i] & {MAX_CLUSTERS{sel_cpu[i]}});
            sub_pop = sub_pop +
                POP_BITS'(s1_data_reg.online_mask[i] && (|cpu_in_cl[i]));
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                cl_pop[c] = cl_pop[c] +
                    POP_BITS'(s1_data_reg.online_mask[i] && cpu_in_cl[i][c]);
            end
        end
    end

    // counter update and result
    always_comb
    begin
        cpu_votes_next = cpu_votes_reg;
        cl_votes_next  = cl_votes_reg;
        sub_votes_next = sub_votes_reg;
        step_err       = 1'b0;
        bres           = '0;
        vote_up        = (s1_data_reg.kind == KIND_ON);
        unique case (s1_data_reg.kind)
            KIND_OFF, KIND_ON:
            begin
                for (int i = 0; i < MAX_CPUS; i++)
                begin
                    if (sel_cpu[i])
                    begin
                        bres              = bump(cpu_votes_reg[i], vote_up);
                        cpu_votes_next[i] = bres[COUNT_BITS-1:0];
                        step_err          = step_err | bres[COUNT_BITS];
                    end
                end
                for (int c = 0; c < MAX_CLUSTERS; c++)
                begin
                    if (cl_hit[c])
                    begin
                        bres             = bump(cl_votes_reg[c], vote_up);
                        cl_votes_next[c] = bres[COUNT_BITS-1:0];
                        step_err         = step_err | bres[COUNT_BITS];
                    end
                end
                if (s1_data_reg.level && (|cl_hit))
                begin
                    bres           = bump(sub_votes_reg, vote_up);
                    sub_votes_next = bres[COUNT_BITS-1:0];
                    step_err       = step_err | bres[COUNT_BITS];
                end
            end
            KIND_RESYNC:
            begin
                for (int i = 0; i < MAX_CPUS; i++)
                begin
                    cpu_votes_next[i] = '0;
                end
                for (int i = 0; i < NUM_MAP_CPUS; i++)
                begin
                    cpu_votes_next[i] =
                        COUNT_BITS'(s1_data_reg.online_mask[i] && cpu_en[i]);
                end
                for (int c = 0; c < MAX_CLUSTERS; c++)
                begin
                    bres             = clamp_pop(cl_pop[c]);
                    cl_votes_next[c] = bres[COUNT_BITS-1:0];
                    step_err         = step_err | bres[COUNT_BITS];
                end
                bres           = clamp_pop(sub_pop);
                sub_votes_next = bres[COUNT_BITS-1:0];
                step_err       = step_err | bres[COUNT_BITS];
            end
            default:
            begin
                step_err = 1'b0;
            end
        endcase

        ccount = '0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            if (cl_hit[c])
            begin
                ccount = cl_votes_next[c];
            end
        end
        sub_wide = RW'(sub_votes_next);
        cl_wide  = RW'(ccount);
        result_next.subsystem_off   = (sub_votes_next == '0);
        result_next.cluster_off     = (|cl_hit) && (ccount == '0);
        result_next.subsystem_count = sub_wide[REPORT_BITS-1:0];
        result_next.cluster_count   = cl_wide[REPORT_BITS-1:0];
        result_next.count_error     = step_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cpus_reg     <= NUM_CPUS_RESET;
            num_clusters_reg <= NUM_CL_RESET;
            cpu_map_reg      <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_CPUS)
            begin
                num_cpus_reg <= cfg_data[NUM_CPUS_BITS-1:0];
            end
            if (cfg_index == CFG_NUM_CLUSTERS)
            begin
                num_clusters_reg <= cfg_data[NUM_CL_BITS-1:0];
            end
            if (cfg_index == CFG_CPU_MAP)
            begin
                cpu_map_reg <= cfg_data[MAP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sub_votes_reg <= '0;
            for (int i = 0; i < MAX_CPUS; i++)
            begin
                cpu_votes_reg[i] <= '0;
            end
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                cl_votes_reg[c] <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                cpu_votes_reg <= cpu_votes_next;
                cl_votes_reg  <= cl_votes_next;
                sub_votes_reg <= sub_votes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result_next;
        end
    end

    `CCPVT_ASSERT_IMP(a_sub_off_matches, out_valid_reg,
        out_data_reg.subsystem_off == (sub_votes_reg == '0))
    `CCPVT_ASSERT_IMP(a_cluster_off_zero, out_valid_reg && out_data_reg.cluster_off,
        out_data_reg.cluster_count == '0)
    `CCPVT_ASSERT_NXT(a_unused_kind_quiet, fire && (s1_data_reg.kind == KIND_NONE),
        !out_data_reg.count_error && $stable(sub_votes_reg))
    `CCPVT_ASSERT_NXT(a_empty_resync, fire && (s1_data_reg.kind == KIND_RESYNC) &&
        (s1_data_reg.online_mask == '0),
        (sub_votes_reg == '0) && !out_data_reg.count_error)

endmodule

>>> bench/ccpvt_status_checker.sv
// ---------------------------------------------------------------------------
// cpu cluster power vote tree status checker
// watches the vote and status channels and the register port, keeps its own
// copy of the cpu, cluster and subsystem counters, predicts the status of
// every accepted vote transaction and compares it with the returned status
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpvt_status_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  ccpvt_pkg::vote_in_t                   in_data,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  ccpvt_pkg::vote_out_t                  out_data,
    input  logic                                  cfg_we,
    input  logic [ccpvt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ccpvt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                    mismatches,
    output int                                    outstanding
);
    import ccpvt_pkg::*;

    localparam int unsigned CPU_SLOTS     = 8;
    localparam int unsigned CLUSTER_SLOTS = 4;
    localparam logic [3:0]  COUNT_MAX     = 4'hF;

    logic [NUM_CPUS_BITS-1:0] num_cpus_q;
    logic [NUM_CL_BITS-1:0]   num_cl_q;
    logic [MAP_BITS-1:0]      map_q;

    logic [3:0] cpu_cnt [CPU_SLOTS];
    logic [3:0] cl_cnt [CLUSTER_SLOTS];
    logic [3:0] sys_cnt;

    vote_out_t status_due [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int unsigned cpu_lim();
        return (num_cpus_q > CPU_SLOTS) ? CPU_SLOTS : int'(num_cpus_q);
    endfunction

    function automatic int unsigned cl_lim();
        return (num_cl_q > CLUSTER_SLOTS) ? CLUSTER_SLOTS : int'(num_cl_q);
    endfunction

    // -1 when the cpu has no usable cluster
    function automatic int cluster_of(input int unsigned cpu);
        int unsigned c;
        if (cpu >= MAP_CPUS)
            return -1;
        c = 32'(map_q[MAP_FIELD_BITS*cpu +: MAP_FIELD_BITS]);
        return (c < cl_lim()) ? int'(c) : -1;
    endfunction

    function automatic bit pinned(input logic [3:0] cnt, input bit up);
        return up ? (cnt == COUNT_MAX) : (cnt == 4'd0);
    endfunction

    function automatic logic [3:0] bumped(input logic [3:0] cnt, input bit up);
        if (pinned(cnt, up))
            return cnt;
        return up ? cnt + 4'd1 : cnt - 4'd1;
    endfunction

    function automatic bit cast_vote(input int unsigned cpu, input bit sys, input bit up);
        bit err;
        int cl;
        if (cpu >= cpu_lim())
            return 1'b0;
        err = pinned(cpu_cnt[cpu], up);
        cpu_cnt[cpu] = bumped(cpu_cnt[cpu], up);
        cl = cluster_of(cpu);
        if (cl < 0)
            return err;
        err |= pinned(cl_cnt[cl], up);
        cl_cnt[cl] = bumped(cl_cnt[cl], up);
        if (sys)
        begin
            err |= pinned(sys_cnt, up);
            sys_cnt = bumped(sys_cnt, up);
        end
        return err;
    endfunction

    function automatic void clear_counts();
        foreach (cpu_cnt[i])
            cpu_cnt[i] = 4'd0;
        foreach (cl_cnt[i])
            cl_cnt[i] = 4'd0;
        sys_cnt = 4'd0;
    endfunction

    function automatic vote_out_t tally_vote(input vote_in_t v);
        vote_out_t r;
        bit err;
        int cl;
        err = 1'b0;
        if (v.kind == KIND_OFF || v.kind == KIND_ON)
            err = cast_vote(32'(v.cpu_index), v.level, v.kind == KIND_ON);
        else if (v.kind == KIND_RESYNC)
        begin
            clear_counts();
            for (int unsigned i = 0; i < MAP_CPUS; i++)
                if (v.online_mask[i])
                    err |= cast_vote(i, 1'b1, 1'b1);
        end
        r.cluster_off   = 1'b0;
        r.cluster_count = '0;
        if (v.cpu_index < cpu_lim())
        begin
            cl = cluster_of(32'(v.cpu_index));
            if (cl >= 0)
            begin
                r.cluster_count = cl_cnt[cl];
                r.cluster_off   = (cl_cnt[cl] == 4'd0);
            end
        end
        r.subsystem_off   = (sys_cnt == 4'd0);
        r.subsystem_count = sys_cnt;
        r.count_error     = err;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cpus_q = NUM_CPUS_RESET;
            num_cl_q   = NUM_CL_RESET;
            map_q      = '0;
            clear_counts();
            status_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_CPUS:     num_cpus_q = cfg_data[NUM_CPUS_BITS-1:0];
                    CFG_NUM_CLUSTERS: num_cl_q = cfg_data[NUM_CL_BITS-1:0];
                    CFG_CPU_MAP:      map_q = cfg_data[MAP_BITS-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                status_due.push_back(tally_vote(in_data));
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: status transaction with nothing expected", $realtime);
                    mismatches++;
                end
                else
                begin
                    vote_out_t exp_s;
                    exp_s = status_due.pop_front();
                    if (out_data.subsystem_off !== exp_s.subsystem_off
                        || out_data.cluster_off !== exp_s.cluster_off
                        || out_data.subsystem_count !== exp_s.subsystem_count
                        || out_data.cluster_count !== exp_s.cluster_count
                        || out_data.count_error !== exp_s.count_error)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: status mismatch: expected sys_off %b cl_off %b ",
                                      "sys %0d cl %0d err %b, got sys_off %b cl_off %b ",
                                      "sys %0d cl %0d err %b"},
                                     $realtime, exp_s.subsystem_off, exp_s.cluster_off,
                                     exp_s.subsystem_count, exp_s.cluster_count,
                                     exp_s.count_error, out_data.subsystem_off,
                                     out_data.cluster_off, out_data.subsystem_count,
                                     out_data.cluster_count, out_data.count_error);
                        mismatches++;
                    end
                end
            end
            outstanding = status_due.size();
        end
    end

endmodule

>>> bench/tb_cpu_cluster_power_vote_tree.sv
// ---------------------------------------------------------------------------
// cpu cluster power vote tree testbench
// directed votes and resyncs at reset settings, then random vote streams
// under several register settings, with bursty input and random or periodic output
// stalls; the status checker predicts and compares every transaction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cpu_cluster_power_vote_tree;
    import ccpvt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    vote_in_t                 in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    vote_out_t                out_data;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          streak_left = 0;
    int unsigned streak_cpu = 0;
    bit          streak_up = 1'b0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;
    logic [7:0]  stall_tick = '0;

    cpu_cluster_power_vote_tree DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ccpvt_status_checker status_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_hold == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_hold <= $urandom_range(32, 200);
        end
        else
            stall_hold <= stall_hold - 1;
        unique case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_tick[2:0] < 3'd3);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_vote(input vote_in_t v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_fields(input logic [KIND_BITS-1:0] kind, input int unsigned cpu,
                               input bit level, input logic [MASK_BITS-1:0] mask);
        vote_in_t v;
        v.kind        = kind;
        v.cpu_index   = CPU_IDX_BITS'(cpu);
        v.level       = level;
        v.online_mask = mask;
        send_vote(v);
    endtask

    // drop valid and wait until every status has come back
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [NUM_CPUS_BITS-1:0] ncpu,
                                input logic [NUM_CL_BITS-1:0] ncl,
                                input logic [MAP_BITS-1:0] map);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_CPUS;
        cfg_data  <= CFG_DATA_BITS'(ncpu);
        @(posedge clk);
        cfg_index <= CFG_NUM_CLUSTERS;
        cfg_data  <= CFG_DATA_BITS'(ncl);
        @(posedge clk);
        cfg_index <= CFG_CPU_MAP;
        cfg_data  <= map;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly valid cluster numbers, some out of range
    function automatic logic [MAP_BITS-1:0] make_map(input int unsigned ncl,
                                                     input int unsigned none_pct);
        logic [MAP_BITS-1:0] m;
        for (int i = 0; i < MAP_CPUS; i++)
        begin
            if ($urandom_range(0, 99) < none_pct)
                m[MAP_FIELD_BITS*i +: MAP_FIELD_BITS] =
                    MAP_FIELD_BITS'($urandom_range(ncl, 7));
            else
                m[MAP_FIELD_BITS*i +: MAP_FIELD_BITS] =
                    MAP_FIELD_BITS'($urandom_range(0, ncl - 1));
        end
        return m;
    endfunction

    // streaks on one cpu drive the counters into saturation
    function automatic vote_in_t make_vote();
        vote_in_t    v;
        int unsigned pick;
        v.cpu_index   = CPU_IDX_BITS'($urandom_range(0, 7));
        v.level       = 1'($urandom_range(0, 1));
        v.online_mask = MASK_BITS'($urandom_range(0, 255));
        if (streak_left == 0 && $urandom_range(0, 99) < 8)
        begin
            streak_left = $urandom_range(10, 20);
            streak_cpu  = $urandom_range(0, 7);
            streak_up   = 1'($urandom_range(0, 1));
        end
        if (streak_left != 0)
        begin
            streak_left--;
            v.kind      = streak_up ? KIND_ON : KIND_OFF;
            v.cpu_index = CPU_IDX_BITS'(streak_cpu);
            v.level     = ($urandom_range(0, 3) != 0);
            return v;
        end
        pick = $urandom_range(0, 99);
        if (pick < 7)
            v.kind = KIND_RESYNC;
        else if (pick < 10)
            v.kind = KIND_NONE;
        else if (pick < 56)
            v.kind = KIND_ON;
        else
            v.kind = KIND_OFF;
        return v;
    endfunction

    task automatic run_random(input int n);
        repeat (n)
            send_vote(make_vote());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all cpus in cluster 0
        send_fields(KIND_ON, 0, 1'b0, 8'h00);
        send_fields(KIND_OFF, 1, 1'b1, 8'hFF);
        send_fields(KIND_NONE, 7, 1'b1, 8'hFF);
        send_fields(KIND_RESYNC, 3, 1'b0, 8'hFF);
        for (int i = 0; i < 8; i++)
            send_fields(KIND_ON, i, 1'b1, 8'h00);
        send_fields(KIND_RESYNC, 0, 1'b1, 8'h00);
        send_fields(KIND_ON, 7, 1'b1, 8'h00);
        send_fields(KIND_OFF, 7, 1'b1, 8'hFF);
        send_fields(KIND_OFF, 7, 1'b0, 8'h00);
        send_fields(KIND_RESYNC, 6, 1'b1, 8'hA5);
        send_fields(KIND_NONE, 0, 1'b0, 8'h00);
        run_random(50);

        settle();
        program_regs(4'd8, 3'd4, make_map(4, 0));
        run_random(80);

        settle();
        program_regs(4'd1, 3'd1, '0);
        run_random(50);

        settle();
        program_regs(4'd0, 3'd0, MAP_BITS'($urandom));
        run_random(20);

        settle();
        program_regs(4'd15, 3'd7, {MAP_BITS{1'b1}});
        run_random(40);

        settle();
        program_regs(NUM_CPUS_BITS'($urandom_range(1, 8)),
                     NUM_CL_BITS'($urandom_range(1, 4)), MAP_BITS'($urandom));
        run_random(80);

        settle();
        program_regs(NUM_CPUS_BITS'($urandom_range(9, 15)),
                     NUM_CL_BITS'($urandom_range(5, 7)), make_map(4, 20));
        run_random(80);

        settle();
        program_regs(4'd8, 3'd4, make_map(4, 10));
        run_random(80);

        settle();
        program_regs(4'd4, 3'd2, make_map(2, 10));
        run_random(70);

        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ccpvt_pkg.sv
rtl/cpu_cluster_power_vote_tree.sv
bench/ccpvt_status_checker.sv
bench/tb_cpu_cluster_power_vote_tree.sv
